@@ design/kle_pkg.sv @@
// kle_pkg: shared types and constants of the keyboard line editor
// no dependencies; used by kle_regs, kle_ctrl and keyboard_line_editor
`default_nettype none

package kle_pkg;

    typedef enum logic [1:0] {
        OP_POINTER = 2'd0,
        OP_KEY     = 2'd1,
        OP_TICK    = 2'd2,
        OP_READ    = 2'd3
    } kle_op_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_EXEC,
        ST_DEL_RD,
        ST_DEL_WR,
        ST_INS_RD,
        ST_INS_WR,
        ST_INS_PUT,
        ST_RD_WAIT,
        ST_DONE
    } kle_state_t;

    // register indexes on the configuration port
    localparam logic [2:0] REG_BOX_LEFT     = 3'd0;
    localparam logic [2:0] REG_BOX_TOP      = 3'd1;
    localparam logic [2:0] REG_BOX_WIDTH    = 3'd2;
    localparam logic [2:0] REG_BOX_HEIGHT   = 3'd3;
    localparam logic [2:0] REG_CAPACITY     = 3'd4;
    localparam logic [2:0] REG_BLINK_PERIOD = 3'd5;

    localparam logic [6:0]  CAPACITY_RESET     = 7'd64;
    localparam logic [15:0] BLINK_PERIOD_RESET = 16'd450;

    // scan codes and characters
    localparam logic [7:0] SC_ENTER       = 8'h1C;
    localparam logic [7:0] SC_DELETE      = 8'h53;
    localparam logic [7:0] SC_LEFT        = 8'h4B;
    localparam logic [7:0] SC_RIGHT       = 8'h4D;
    localparam int         SC_BREAK_BIT   = 7;
    localparam logic [7:0] CH_BACKSPACE   = 8'd8;
    localparam logic [7:0] CH_FIRST_PRINT = 8'd32;
    localparam logic [7:0] CH_LAST_PRINT  = 8'd126;

    typedef struct packed {
        logic [11:0] box_left;
        logic [11:0] box_top;
        logic [11:0] box_width;
        logic [11:0] box_height;
        logic [6:0]  capacity;
        logic [15:0] blink_period;
    } kle_cfg_t;

    typedef struct packed {
        kle_op_t     operation;
        logic [11:0] pointer_x;
        logic [11:0] pointer_y;
        logic        left_pressed;
        logic [7:0]  scan_code;
        logic [7:0]  key_char;
        logic [31:0] time_ms;
        logic [5:0]  read_index;
    } kle_item_t;

    typedef struct packed {
        logic [5:0] text_length;
        logic [5:0] caret_position;
        logic       is_focused;
        logic       is_hovered;
        logic       caret_visible;
        logic [7:0] char_at_index;
    } kle_result_t;

endpackage

`default_nettype wire

@@ design/kle_regs.sv @@
// kle_regs: configuration registers behind the apb-style port
// depends on kle_pkg for register indexes, reset values and kle_cfg_t
`default_nettype none

module kle_regs
(
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             psel,
    input  wire logic             penable,
    input  wire logic             pwrite,
    input  wire logic [4:0]       paddr,
    input  wire logic [31:0]      pwdata,
    output logic      [31:0]      prdata,
    output logic                  pready,
    output kle_pkg::kle_cfg_t     cfg
);

    kle_pkg::kle_cfg_t cfg_reg;
    kle_pkg::kle_cfg_t cfg_next;
    logic              wr_en;
    logic [2:0]        reg_index;

    assign pready    = 1'b1;
    assign wr_en     = psel & penable & pwrite;
    assign reg_index = paddr[4:2];
    assign cfg       = cfg_reg;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (wr_en)
        begin
            unique case (reg_index)
                kle_pkg::REG_BOX_LEFT:     cfg_next.box_left     = pwdata[11:0];
                kle_pkg::REG_BOX_TOP:      cfg_next.box_top      = pwdata[11:0];
                kle_pkg::REG_BOX_WIDTH:    cfg_next.box_width    = pwdata[11:0];
                kle_pkg::REG_BOX_HEIGHT:   cfg_next.box_height   = pwdata[11:0];
                kle_pkg::REG_CAPACITY:     cfg_next.capacity     = pwdata[6:0];
                kle_pkg::REG_BLINK_PERIOD: cfg_next.blink_period = pwdata[15:0];
                default:                   cfg_next = cfg_reg;
            endcase
        end
    end

    always_comb
    begin
        unique case (reg_index)
            kle_pkg::REG_BOX_LEFT:     prdata = 32'(cfg_reg.box_left);
            kle_pkg::REG_BOX_TOP:      prdata = 32'(cfg_reg.box_top);
            kle_pkg::REG_BOX_WIDTH:    prdata = 32'(cfg_reg.box_width);
            kle_pkg::REG_BOX_HEIGHT:   prdata = 32'(cfg_reg.box_height);
            kle_pkg::REG_CAPACITY:     prdata = 32'(cfg_reg.capacity);
            kle_pkg::REG_BLINK_PERIOD: prdata = 32'(cfg_reg.blink_period);
            default:                   prdata = 32'd0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.box_left     <= 12'd0;
            cfg_reg.box_top      <= 12'd0;
            cfg_reg.box_width    <= 12'd0;
            cfg_reg.box_height   <= 12'd0;
            cfg_reg.capacity     <= kle_pkg::CAPACITY_RESET;
            cfg_reg.blink_period <= kle_pkg::BLINK_PERIOD_RESET;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

endmodule

`default_nettype wire

@@ design/kle_text_mem.sv @@
// kle_text_mem: character store, one write port and one registered read port
// no dependencies
`default_nettype none

module kle_text_mem
#(
    parameter int BUFFER_DEPTH = 64,
    parameter int AW           = 6
)
(
    input  wire logic          clk,
    input  wire logic          we,
    input  wire logic [AW-1:0] waddr,
    input  wire logic [7:0]    wdata,
    input  wire logic [AW-1:0] raddr,
    output logic      [7:0]    rdata
);

    logic [7:0] mem [BUFFER_DEPTH];
    logic [7:0] rdata_reg;

    assign rdata = rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

endmodule

`default_nettype wire

@@ design/kle_ctrl.sv @@
// kle_ctrl: event sequencer, editor state and result register
// depends on kle_pkg; drives kle_text_mem one element per shift step
`default_nettype none

module kle_ctrl
#(
    parameter int BUFFER_DEPTH = 64,
    parameter int AW           = 6
)
(
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire kle_pkg::kle_cfg_t    cfg,
    input  wire logic                 in_valid,
    output logic                      in_ready,
    input  wire kle_pkg::kle_item_t   in_item,
    output logic                      out_valid,
    input  wire logic                 out_ready,
    output kle_pkg::kle_result_t      out_result,
    output logic                      mem_we,
    output logic      [AW-1:0]        mem_waddr,
    output logic      [7:0]           mem_wdata,
    output logic      [AW-1:0]        mem_raddr,
    input  wire logic [7:0]           mem_rdata
);

    localparam int LW = $clog2(BUFFER_DEPTH + 1);
    localparam int CW = ((LW > 7) ? LW : 7) + 1;

    kle_pkg::kle_state_t  state_reg, state_next;
    kle_pkg::kle_item_t   item_reg, item_next;
    kle_pkg::kle_result_t result_reg, result_next;
    logic [AW-1:0]        len_reg, len_next;
    logic [AW-1:0]        caret_reg, caret_next;
    logic [AW-1:0]        idx_reg, idx_next;
    logic                 focus_reg, focus_next;
    logic                 hover_reg, hover_next;
    logic                 phase_reg, phase_next;
    logic [31:0]          last_reg, last_next;
    logic [7:0]           char_reg, char_next;
    logic                 out_valid_reg, out_valid_next;

    logic          hit;
    logic          key_live;
    logic          is_bs, is_del, is_left, is_right, is_print;
    logic          do_bs, do_del, do_left, do_right, do_ins;
    logic [CW-1:0] eff_cap;
    logic          ins_room;
    logic          shift_more;
    logic          idx_above_caret;
    logic          rd_in_range;
    logic [31:0]   elapsed;
    logic          tick_due;
    logic          out_load;

    // inclusive rectangle test
    assign hit = (item_reg.pointer_x >= cfg.box_left)
              && (13'(item_reg.pointer_x) <= 13'(cfg.box_left) + 13'(cfg.box_width))
              && (item_reg.pointer_y >= cfg.box_top)
              && (13'(item_reg.pointer_y) <= 13'(cfg.box_top) + 13'(cfg.box_height));

    assign key_live = focus_reg && !item_reg.scan_code[kle_pkg::SC_BREAK_BIT]
                   && (item_reg.scan_code != kle_pkg::SC_ENTER);
    assign is_bs    = item_reg.key_char == kle_pkg::CH_BACKSPACE;
    assign is_del   = item_reg.scan_code == kle_pkg::SC_DELETE;
    assign is_left  = item_reg.scan_code == kle_pkg::SC_LEFT;
    assign is_right = item_reg.scan_code == kle_pkg::SC_RIGHT;
    assign is_print = (item_reg.key_char >= kle_pkg::CH_FIRST_PRINT)
                   && (item_reg.key_char <= kle_pkg::CH_LAST_PRINT);

    assign eff_cap  = (CW'(cfg.capacity) > CW'(BUFFER_DEPTH)) ? CW'(BUFFER_DEPTH)
                                                               : CW'(cfg.capacity);
    assign ins_room = (CW'(len_reg) + CW'(2)) <= eff_cap;

    assign do_bs    = key_live && is_bs && (caret_reg != '0) && (len_reg != '0);
    assign do_del   = key_live && !is_bs && is_del && (caret_reg < len_reg);
    assign do_left  = key_live && !is_bs && !is_del && is_left && (caret_reg != '0);
    assign do_right = key_live && !is_bs && !is_del && !is_left && is_right
                   && (caret_reg < len_reg);
    assign do_ins   = key_live && !is_bs && !is_del && !is_left && !is_right
                   && is_print && ins_room;

    assign shift_more      = (CW'(idx_reg) + CW'(1)) < CW'(len_reg);
    assign idx_above_caret = idx_reg > caret_reg;
    assign rd_in_range     = (CW'(item_reg.read_index) < CW'(len_reg))
                          && (CW'(item_reg.read_index) < CW'(BUFFER_DEPTH));

    assign elapsed  = item_reg.time_ms - last_reg;
    assign tick_due = elapsed > 32'(cfg.blink_period);

    assign out_load   = (state_reg == kle_pkg::ST_DONE) && (!out_valid_reg || out_ready);
    assign out_valid  = out_valid_reg;
    assign out_result = result_reg;

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            kle_pkg::ST_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = kle_pkg::ST_EXEC;
                end
            end
            kle_pkg::ST_EXEC:
            begin
                unique case (item_reg.operation)
                    kle_pkg::OP_POINTER: state_next = kle_pkg::ST_DONE;
                    kle_pkg::OP_TICK:    state_next = kle_pkg::ST_DONE;
                    kle_pkg::OP_KEY:
                    begin
                        priority if (do_bs || do_del)
                            state_next = kle_pkg::ST_DEL_RD;
                        else if (do_ins)
                            state_next = kle_pkg::ST_INS_RD;
                        else
                            state_next = kle_pkg::ST_DONE;
                    end
                    kle_pkg::OP_READ:
                        state_next = rd_in_range ? kle_pkg::ST_RD_WAIT : kle_pkg::ST_DONE;
                    default: state_next = kle_pkg::ST_DONE;
                endcase
            end
            kle_pkg::ST_DEL_RD:
                state_next = shift_more ? kle_pkg::ST_DEL_WR : kle_pkg::ST_DONE;
            kle_pkg::ST_DEL_WR:
                state_next = kle_pkg::ST_DEL_RD;
            kle_pkg::ST_INS_RD:
                state_next = idx_above_caret ? kle_pkg::ST_INS_WR : kle_pkg::ST_INS_PUT;
            kle_pkg::ST_INS_WR:
                state_next = kle_pkg::ST_INS_RD;
            kle_pkg::ST_INS_PUT:
                state_next = kle_pkg::ST_DONE;
            kle_pkg::ST_RD_WAIT:
                state_next = kle_pkg::ST_DONE;
            kle_pkg::ST_DONE:
            begin
                if (out_load)
                begin
                    state_next = kle_pkg::ST_IDLE;
                end
            end
            default: state_next = kle_pkg::ST_IDLE;
        endcase
    end

    // datapath and memory controls
    always_comb
    begin
        in_ready       = 1'b0;
        item_next      = item_reg;
        len_next       = len_reg;
        caret_next     = caret_reg;
        idx_next       = idx_reg;
        focus_next     = focus_reg;
        hover_next     = hover_reg;
        phase_next     = phase_reg;
        last_next      = last_reg;
        char_next      = char_reg;
        result_next    = result_reg;
        out_valid_next = out_valid_reg && !out_ready;
        mem_we         = 1'b0;
        mem_waddr      = idx_reg;
        mem_wdata      = mem_rdata;
        mem_raddr      = idx_reg;

        unique case (state_reg)
            kle_pkg::ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    item_next = in_item;
                end
            end
            kle_pkg::ST_EXEC:
            begin
                char_next = 8'd0;
                unique case (item_reg.operation)
                    kle_pkg::OP_POINTER:
                    begin
                        hover_next = hit;
                        if (item_reg.left_pressed)
                        begin
                            if (hit)
                            begin
                                focus_next = 1'b1;
                                phase_next = 1'b1;
                                last_next  = item_reg.time_ms;
                                caret_next = len_reg;
                            end
                            else
                            begin
                                focus_next = 1'b0;
                            end
                        end
                    end
                    kle_pkg::OP_KEY:
                    begin
                        priority if (do_bs)
                        begin
                            idx_next   = caret_reg - AW'(1);
                            caret_next = caret_reg - AW'(1);
                        end
                        else if (do_del)
                            idx_next = caret_reg;
                        else if (do_left)
                            caret_next = caret_reg - AW'(1);
                        else if (do_right)
                            caret_next = caret_reg + AW'(1);
                        else if (do_ins)
                            idx_next = len_reg;
                        else
                            idx_next = idx_reg;
                    end
                    kle_pkg::OP_TICK:
                    begin
                        if (focus_reg)
                        begin
                            if (tick_due)
                            begin
                                phase_next = !phase_reg;
                                last_next  = item_reg.time_ms;
                            end
                        end
                        else
                        begin
                            phase_next = 1'b0;
                        end
                    end
                    kle_pkg::OP_READ:
                        mem_raddr = AW'(item_reg.read_index);
                    default: char_next = 8'd0;
                endcase
            end
            kle_pkg::ST_DEL_RD:
            begin
                mem_raddr = idx_reg + AW'(1);
                if (!shift_more)
                begin
                    len_next = len_reg - AW'(1);
                end
            end
            kle_pkg::ST_DEL_WR:
            begin
                mem_we   = 1'b1;
                idx_next = idx_reg + AW'(1);
            end
            kle_pkg::ST_INS_RD:
                mem_raddr = idx_reg - AW'(1);
            kle_pkg::ST_INS_WR:
            begin
                mem_we   = 1'b1;
                idx_next = idx_reg - AW'(1);
            end
            kle_pkg::ST_INS_PUT:
            begin
                mem_we     = 1'b1;
                mem_waddr  = caret_reg;
                mem_wdata  = item_reg.key_char;
                len_next   = len_reg + AW'(1);
                caret_next = caret_reg + AW'(1);
            end
            kle_pkg::ST_RD_WAIT:
                char_next = mem_rdata;
            kle_pkg::ST_DONE:
            begin
                if (out_load)
                begin
                    out_valid_next             = 1'b1;
                    result_next.text_length    = 6'(len_reg);
                    result_next.caret_position = 6'(caret_reg);
                    result_next.is_focused     = focus_reg;
                    result_next.is_hovered     = hover_reg;
                    result_next.caret_visible  = phase_reg;
                    result_next.char_at_index  = char_reg;
                end
            end
            default: in_ready = 1'b0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= kle_pkg::ST_IDLE;
            len_reg       <= '0;
            caret_reg     <= '0;
            focus_reg     <= 1'b0;
            hover_reg     <= 1'b0;
            phase_reg     <= 1'b1;
            last_reg      <= 32'd0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            len_reg       <= len_next;
            caret_reg     <= caret_next;
            focus_reg     <= focus_next;
            hover_reg     <= hover_next;
            phase_reg     <= phase_next;
            last_reg      <= last_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        item_reg   <= item_next;
        idx_reg    <= idx_next;
        char_reg   <= char_next;
        result_reg <= result_next;
    end

    a_caret_in_text: assert property (@(posedge clk) disable iff (!rst_n)
        caret_reg <= len_reg)
        else $error("caret beyond text length");

    a_len_bound: assert property (@(posedge clk) disable iff (!rst_n)
        CW'(len_reg) <= CW'(BUFFER_DEPTH - 1))
        else $error("text length beyond buffer");

    a_write_in_shift: assert property (@(posedge clk) disable iff (!rst_n)
        mem_we |-> (state_reg == kle_pkg::ST_DEL_WR || state_reg == kle_pkg::ST_INS_WR
                    || state_reg == kle_pkg::ST_INS_PUT))
        else $error("store written outside an edit step");

    a_accept_starts: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) |=> (state_reg == kle_pkg::ST_EXEC))
        else $error("accepted transfer not started");

    a_shift_needs_focus: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == kle_pkg::ST_DEL_RD || state_reg == kle_pkg::ST_INS_RD) |-> focus_reg)
        else $error("edit running while unfocused");

endmodule

`default_nettype wire

@@ design/keyboard_line_editor.sv @@
// keyboard_line_editor: one-line text buffer with caret, pointer focus and blink
// insert, delete and backspace move the entries from the caret onward through a shift
// loop, one entry per read and write step; pointer, key move, tick and read do not shift
// flow: one transfer at a time, the next accepted once the result is queued
// reset: asynchronous active low, resets control state; text store is not cleared
// depends on kle_pkg, kle_regs, kle_text_mem, kle_ctrl
`default_nettype none

module keyboard_line_editor
#(
    parameter int BUFFER_DEPTH = 64
)
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    // apb-style configuration
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [4:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic      [31:0] prdata,
    output logic             pready,
    // input stream
    input  wire logic        s_tvalid,
    output logic             s_tready,
    // pointer_x, pointer_y, left_pressed, scan_code, key_char, time_ms, read_index
    input  wire logic [79:0] s_tdata,
    // operation
    input  wire logic [1:0]  s_tuser,
    // result stream
    output logic             m_tvalid,
    input  wire logic        m_tready,
    // text_length, caret_position, is_focused, is_hovered, caret_visible, char_at_index
    output logic      [23:0] m_tdata
);

    localparam int AW = (BUFFER_DEPTH > 1) ? $clog2(BUFFER_DEPTH) : 1;

    kle_pkg::kle_cfg_t    cfg;
    kle_pkg::kle_item_t   in_item;
    kle_pkg::kle_result_t out_result;
    logic                 mem_we;
    logic [AW-1:0]        mem_waddr;
    logic [7:0]           mem_wdata;
    logic [AW-1:0]        mem_raddr;
    logic [7:0]           mem_rdata;

    // unpack input transfer
    assign in_item.operation    = kle_pkg::kle_op_t'(s_tuser);
    assign in_item.pointer_x    = s_tdata[11:0];
    assign in_item.pointer_y    = s_tdata[23:12];
    assign in_item.left_pressed = s_tdata[24];
    assign in_item.scan_code    = s_tdata[32:25];
    assign in_item.key_char     = s_tdata[40:33];
    assign in_item.time_ms      = s_tdata[72:41];
    assign in_item.read_index   = s_tdata[78:73];

    // pack result transfer
    assign m_tdata = {1'b0,
                      out_result.char_at_index,
                      out_result.caret_visible,
                      out_result.is_hovered,
                      out_result.is_focused,
                      out_result.caret_position,
                      out_result.text_length};

    kle_regs u_regs
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    kle_text_mem
    #(
        .BUFFER_DEPTH (BUFFER_DEPTH),
        .AW           (AW)
    )
    u_mem
    (
        .clk   (clk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

    kle_ctrl
    #(
        .BUFFER_DEPTH (BUFFER_DEPTH),
        .AW           (AW)
    )
    u_ctrl
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg        (cfg),
        .in_valid   (s_tvalid),
        .in_ready   (s_tready),
        .in_item    (in_item),
        .out_valid  (m_tvalid),
        .out_ready  (m_tready),
        .out_result (out_result),
        .mem_we     (mem_we),
        .mem_waddr  (mem_waddr),
        .mem_wdata  (mem_wdata),
        .mem_raddr  (mem_raddr),
        .mem_rdata  (mem_rdata)
    );

endmodule

`default_nettype wire
